@@ design/pct_pkg.sv @@
// shared types and constants for the polyline column-top rasterizer
// no dependencies
package pct_pkg;
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_VERTEX = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;
  localparam int CoordW = 16;
  localparam int FracHalf = 32;
  typedef logic signed [CoordW-1:0] coord_t;
endpackage

@@ design/pct_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module pct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/polyline_column_top_raster_core.sv @@
// polyline column-top rasterizer: sequencer, shared divider, column store
// depends on pct_pkg and pct_ram
//
//  channel  ports                                   handshake
//  input    in_mode in_start_polyline in_vertex_x   start & !busy
//           in_vertex_y in_column_index
//  result   out_column_top out_column_reached       out_valid, one cycle
//  config   cfg_we cfg_wdata                        cfg_we, no wait
//
// a read keeps busy high through S_RREAD and S_ROUT; its result strobe is
// registered in S_ROUT
// a clear leaves busy low: the reached marks are flip-flops and drop at once
// a segment passes a setup state, then per column: multiply, 40 restoring
// divide steps (one quotient bit per cycle), store read, update
// reset clears control state and the reached marks; no clearing pass
// the receiver cannot stall; busy is high while an item is in work
module polyline_column_top_raster_core
  import pct_pkg::*;
#(
  parameter int MAX_COLUMNS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic        in_start_polyline,
  input  logic signed [15:0] in_vertex_x,
  input  logic signed [15:0] in_vertex_y,
  input  logic [7:0]  in_column_index,
  output logic        out_valid,
  output logic signed [15:0] out_column_top,
  output logic        out_column_reached,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);
  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int PW = AW + 2;          // signed column numbers
  localparam int QW = 40;              // divider width
  localparam int CW = $clog2(QW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_RREAD = 4'd6;
  localparam logic [3:0] S_ROUT  = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic [8:0] width_r;
  coord_t px_r, py_r;
  logic signed [16:0] xa_r, ya_r, dy_r;
  logic [16:0] dx_r;
  logic signed [PW-1:0] p_r, p1_r;
  logic [QW-1:0] rem_r, quo_r;
  logic [QW-1:0] num_r;
  logic neg_r;
  logic [CW-1:0] cnt_r;
  logic signed [16:0] y_r;
  logic [MAX_COLUMNS-1:0] valid_r;
  logic [AW-1:0] ridx_r;
  logic ridx_ok_r;

  // column store
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0] ram_rdata;
  pct_ram #(.WIDTH(16), .DEPTH(MAX_COLUMNS)) u_tops (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(y_r[15:0]), .rdata(ram_rdata)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);

  // segment bounds, ends ordered by x
  logic signed [16:0] vx_e, vy_e, pxe, pye, lo_x, hi_x, lo_y, hi_y;
  logic signed [16:0] p0_c, p1_c;
  logic signed [PW-1:0] p0_s, p1_s, wm1;
  assign vx_e = 17'(in_vertex_x);
  assign vy_e = 17'(in_vertex_y);
  assign pxe  = 17'(px_r);
  assign pye  = 17'(py_r);
  always_comb begin
    if (vx_e < pxe) begin
      lo_x = vx_e; lo_y = vy_e; hi_x = pxe; hi_y = pye;
    end else begin
      lo_x = pxe; lo_y = pye; hi_x = vx_e; hi_y = vy_e;
    end
    // ceil((xa-32)/64) = floor((xa+31)/64), arithmetic shifts floor
    p0_c = (lo_x + 17'sd31) >>> 6;
    p1_c = (hi_x - 17'sd32) >>> 6;
    wm1 = (32'(width_r) > MAX_COLUMNS) ? PW'(MAX_COLUMNS - 1)
                                       : PW'($signed({1'b0, width_r}) - 10'sd1);
    // bounds are clamped to the columns; a range wholly past either edge is empty
    p0_s = (p0_c < 0) ? '0 : (p0_c > 17'(wm1)) ? wm1 + PW'(1) : PW'(p0_c);
    p1_s = (p1_c > 17'(wm1)) ? wm1 : (p1_c < 0) ? -PW'(1) : PW'(p1_c);
  end

  // numerator for the current column
  logic signed [17:0] off_c;
  logic signed [35:0] prod_c;
  assign off_c  = 18'(($signed({p_r, 6'd0})) + 18'sd32 - 18'(xa_r));
  assign prod_c = 36'(off_c) * 36'(dy_r);

  // one restoring divide step
  logic [QW:0] trial;
  assign trial = {rem_r, num_r[QW-1]} - {{(QW-16){1'b0}}, dx_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_VERTEX && !in_start_polyline) state_nxt = S_SETUP;
          else if (in_mode == MODE_READ) state_nxt = S_RREAD;
        end
      end
      S_SETUP: state_nxt = (dx_r == '0 || p_r > p1_r) ? S_IDLE : S_MUL;
      S_MUL:   state_nxt = S_DIV;
      S_DIV:   state_nxt = (cnt_r == CW'(QW - 1)) ? S_RD : S_DIV;
      S_RD:    state_nxt = S_UPD;
      S_UPD:   state_nxt = (p_r == p1_r) ? S_IDLE : S_MUL;
      S_RREAD: state_nxt = S_ROUT;
      S_ROUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // quotient floor: q = trunc(|n|/d), negative n with remainder rounds down
  logic signed [16:0] qf;
  always_comb begin
    if (neg_r) qf = -17'($signed({1'b0, quo_r[15:0]})) - ((rem_r != '0) ? 17'sd1 : 17'sd0);
    else       qf = 17'($signed({1'b0, quo_r[15:0]}));
  end

  assign ram_addr = (state_r == S_RREAD) ? ridx_r : p_r[AW-1:0];
  logic upd_take;
  assign upd_take = !valid_r[p_r[AW-1:0]] || ($signed(y_r) < 17'($signed(ram_rdata)));
  assign ram_we = (state_r == S_UPD) && upd_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      width_r <= 9'd172;
      px_r <= '0;
      py_r <= '0;
      valid_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) width_r <= cfg_wdata;
      if (accept && in_mode == MODE_CLEAR) valid_r <= '0;
      if (accept && in_mode == MODE_VERTEX) begin
        px_r <= in_vertex_x;
        py_r <= in_vertex_y;
      end
      if (ram_we) valid_r[p_r[AW-1:0]] <= 1'b1;
      if (state_r == S_ROUT) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      xa_r <= lo_x;
      ya_r <= lo_y;
      dx_r <= 17'(hi_x - lo_x);
      dy_r <= hi_y - lo_y;
      p_r  <= p0_s;
      p1_r <= p1_s;
      ridx_ok_r <= (32'(in_column_index) < MAX_COLUMNS);
      ridx_r <= AW'(in_column_index);
    end
    if (state_r == S_MUL) begin
      neg_r <= prod_c < 0;
      num_r <= QW'(prod_c < 0 ? -prod_c : prod_c);
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == S_DIV) begin
      num_r <= {num_r[QW-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      if (!trial[QW]) begin
        rem_r <= trial[QW-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[QW-2:0], num_r[QW-1]};
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
    if (state_r == S_RD) y_r <= ya_r + qf;
    if (state_r == S_UPD) p_r <= p_r + 1'b1;
    if (state_r == S_RREAD) begin
      out_column_reached <= ridx_ok_r && valid_r[ridx_r];
    end
    if (state_r == S_ROUT) begin
      out_column_top <= out_column_reached ? ram_rdata : 16'sd0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(state_r) == S_ROUT)
    else $error("result without read");
  assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> state_r == S_UPD)
    else $error("store write outside update");
  assert property (@(posedge clk) disable iff (!rst_n) (start && busy) |=> $stable(px_r))
    else $error("previous point moved while busy");
endmodule
